// ----- src/m2p_pkg.sv -----
`timescale 1ns / 1ps

package m2p_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned EXP_WIDTH  = 31;
  // remaining-bit counter, counts EXP_WIDTH-1 down to zero
  localparam int unsigned CNT_W      = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  typedef logic [DATA_WIDTH-1:0] m2p_word_t;

  // result entry being worked on, row then column
  typedef enum logic [1:0] {
    ENT_00 = 2'd0,
    ENT_01 = 2'd1,
    ENT_10 = 2'd2,
    ENT_11 = 2'd3
  } m2p_entry_e;

  // operands for one result entry: a0*b0 + a1*b1
  typedef struct packed {
    m2p_word_t a0;
    m2p_word_t b0;
    m2p_word_t a1;
    m2p_word_t b1;
  } m2p_mac_op_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] base_00;
    logic signed [DATA_WIDTH-1:0] base_01;
    logic signed [DATA_WIDTH-1:0] base_10;
    logic signed [DATA_WIDTH-1:0] base_11;
    logic        [EXP_WIDTH-1:0]  exponent;
  } m2p_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] power_00;
    logic signed [DATA_WIDTH-1:0] power_01;
    logic signed [DATA_WIDTH-1:0] power_10;
    logic signed [DATA_WIDTH-1:0] power_11;
  } m2p_out_t;

endpackage

// ----- src/m2p_mac.sv -----
`timescale 1ns / 1ps

// two-stage dot product of two pairs, wrapping to the data width
module m2p_mac import m2p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_vld_i,
  input  m2p_mac_op_t req_op_i,
  output logic        rsp_vld_o,
  output m2p_word_t   rsp_o
);

  m2p_word_t prod0_d, prod1_d;
  m2p_word_t prod0_q, prod1_q;
  m2p_word_t sum_q;
  logic      vld1_q, vld2_q;

  // only the low bits of each product survive the wrap
  assign prod0_d = req_op_i.a0 * req_op_i.b0;
  assign prod1_d = req_op_i.a1 * req_op_i.b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= req_vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod0_q <= prod0_d;
    prod1_q <= prod1_d;
    sum_q   <= prod0_q + prod1_q;
  end

  assign rsp_vld_o = vld2_q;
  assign rsp_o     = sum_q;

endmodule

// ----- src/matrix2x2_power.sv -----
`timescale 1ns / 1ps

// 2x2 matrix power by binary exponentiation. A transaction on the input
// channel carries a signed 2x2 base matrix and an unsigned exponent; one
// transaction later leaves on the output channel with the base raised to
// that power, every entry wrapped to DATA_WIDTH bits as two's complement
// (exponent zero gives the identity). The exponent is scanned from its top
// bit down: each bit squares the running product, and a set bit then
// multiplies it on the left by the base. All matrix products go through one
// shared unit of two multipliers and an adder, which yields one result
// entry per cycle. The block handles one transaction at a time:
// in_stall_o stays high from acceptance until the result has been taken.
module matrix2x2_power import m2p_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  m2p_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output m2p_out_t out_data_o
);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_DONE   = 4'b1000
  } m2p_state_e;

  m2p_state_e state_q, state_d;

  // matrices held entry by entry in row-major order
  m2p_word_t  base_q [4];
  m2p_word_t  base_d [4];
  m2p_word_t  acc_q  [4];
  m2p_word_t  acc_d  [4];
  m2p_word_t  nxt_q  [4];

  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
  logic [1:0]           iss_cnt_q, iss_cnt_d;
  logic [1:0]           ret_cnt_q, ret_cnt_d;
  logic                 iss_act_q, iss_act_d;

  logic        mac_req;
  m2p_mac_op_t mac_op;
  logic        mac_vld;
  m2p_word_t   mac_rsp;
  logic        phase_end;

  // left operand is the running product when squaring, the base otherwise
  m2p_word_t x00, x01, x10, x11;

  assign x00 = (state_q == ST_SQUARE) ? acc_q[0] : base_q[0];
  assign x01 = (state_q == ST_SQUARE) ? acc_q[1] : base_q[1];
  assign x10 = (state_q == ST_SQUARE) ? acc_q[2] : base_q[2];
  assign x11 = (state_q == ST_SQUARE) ? acc_q[3] : base_q[3];

  // operand pick for the entry being issued: row of x times column of acc
  always_comb begin
    unique case (iss_cnt_q)
      ENT_00: mac_op = '{a0: x00, b0: acc_q[0], a1: x01, b1: acc_q[2]};
      ENT_01: mac_op = '{a0: x00, b0: acc_q[1], a1: x01, b1: acc_q[3]};
      ENT_10: mac_op = '{a0: x10, b0: acc_q[0], a1: x11, b1: acc_q[2]};
      ENT_11: mac_op = '{a0: x10, b0: acc_q[1], a1: x11, b1: acc_q[3]};
      default: mac_op = '{a0: x00, b0: acc_q[0], a1: x01, b1: acc_q[2]};
    endcase
  end

  m2p_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (mac_req),
    .req_op_i  (mac_op),
    .rsp_vld_o (mac_vld),
    .rsp_o     (mac_rsp)
  );

  // the last entry of a product is back
  assign phase_end = mac_vld && (ret_cnt_q == 2'(ENT_11));

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    acc_d     = acc_q;
    exp_d     = exp_q;
    bit_cnt_d = bit_cnt_q;
    iss_cnt_d = iss_cnt_q;
    ret_cnt_d = ret_cnt_q;
    iss_act_d = iss_act_q;
    mac_req   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          base_d[0] = in_data_i.base_00;
          base_d[1] = in_data_i.base_01;
          base_d[2] = in_data_i.base_10;
          base_d[3] = in_data_i.base_11;
          // running product starts as the identity
          acc_d[0]  = DATA_WIDTH'(1);
          acc_d[1]  = '0;
          acc_d[2]  = '0;
          acc_d[3]  = DATA_WIDTH'(1);
          exp_d     = in_data_i.exponent;
          bit_cnt_d = CNT_W'(EXP_WIDTH - 1);
          iss_cnt_d = '0;
          ret_cnt_d = '0;
          iss_act_d = 1'b1;
          state_d   = ST_SQUARE;
        end
      end

      ST_SQUARE, ST_MULT: begin
        // issue the four entries back to back
        if (iss_act_q) begin
          mac_req   = 1'b1;
          iss_cnt_d = iss_cnt_q + 2'd1;
          if (iss_cnt_q == 2'(ENT_11)) begin
            iss_act_d = 1'b0;
          end
        end
        if (mac_vld) begin
          ret_cnt_d = ret_cnt_q + 2'd1;
        end
        if (phase_end) begin
          acc_d[0]  = nxt_q[0];
          acc_d[1]  = nxt_q[1];
          acc_d[2]  = nxt_q[2];
          acc_d[3]  = mac_rsp;
          iss_cnt_d = '0;
          iss_act_d = 1'b1;
          priority if (state_q == ST_SQUARE && exp_q[EXP_WIDTH-1]) begin
            state_d = ST_MULT;
          end else if (bit_cnt_q == '0) begin
            iss_act_d = 1'b0;
            state_d   = ST_DONE;
          end else begin
            // move on to the next lower exponent bit
            exp_d     = exp_q << 1;
            bit_cnt_d = bit_cnt_q - CNT_W'(1);
            state_d   = ST_SQUARE;
          end
        end
      end

      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      iss_cnt_q <= '0;
      ret_cnt_q <= '0;
      iss_act_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      iss_cnt_q <= iss_cnt_d;
      ret_cnt_q <= ret_cnt_d;
      iss_act_q <= iss_act_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
    if (mac_vld) begin
      nxt_q[ret_cnt_q] <= mac_rsp;
    end
  end

  // handshakes: busy from acceptance until the result is taken
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign out_data_o.power_00 = acc_q[0];
  assign out_data_o.power_01 = acc_q[1];
  assign out_data_o.power_10 = acc_q[2];
  assign out_data_o.power_11 = acc_q[3];

  // results from the shared unit only come back during a product
  a_rsp_in_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld |-> (state_q == ST_SQUARE || state_q == ST_MULT))
    else $error("multiplier result outside a matrix product");

  // returns never overtake issues within a product
  a_ret_behind_iss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_act_q |-> (ret_cnt_q <= iss_cnt_q))
    else $error("more entries returned than issued");

  // a result is offered only once every exponent bit has been scanned
  a_done_all_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (bit_cnt_q == '0))
    else $error("result offered before the last exponent bit");

  // no new transaction is taken while a result is still waiting
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // nothing is issued once the product has gone out
  a_no_issue_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE || state_q == ST_IDLE) |-> !mac_req)
    else $error("multiplier issue outside a matrix product");

endmodule

// ----- bench/matrix2x2_power_tb.sv -----
`timescale 1ns / 1ps

module matrix2x2_power_tb;
  import m2p_pkg::*;

  // entry extremes and the largest exponent as plain ints for the stimulus table
  localparam int          WMAX = 32'h7FFF_FFFF;
  localparam int          WMIN = 32'h8000_0000;
  localparam int unsigned EMAX = 32'h7FFF_FFFF;

  // one 2x2 matrix, indexed by result entry
  typedef m2p_word_t mat2_t [4];

  // receiver stall behaviour, chosen afresh for each segment
  typedef enum {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  // directed stimulus: a fixed result where it is obvious, else predicted
  typedef struct {
    m2p_in_t  stim;
    bit       known;
    m2p_out_t power;
  } stim_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  m2p_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  m2p_out_t out_data_o;

  // powers still owed by the block, oldest first
  m2p_out_t  power_q [$];
  stim_row_t dir_rows [$];

  int       n_errors   = 0;
  int       n_results  = 0;
  int       burst_left = 0;
  int       hold_left  = 0;
  int       seg_left   = 0;
  int       phase      = 0;
  rx_mode_e seg_mode   = RX_FREE;
  m2p_out_t want;

  matrix2x2_power dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // product of two matrices, every sum and product wrapped to the word width
  function automatic mat2_t mat_product(input mat2_t x, input mat2_t y);
    mat2_t r;
    r[ENT_00] = x[ENT_00] * y[ENT_00] + x[ENT_01] * y[ENT_10];
    r[ENT_01] = x[ENT_00] * y[ENT_01] + x[ENT_01] * y[ENT_11];
    r[ENT_10] = x[ENT_10] * y[ENT_00] + x[ENT_11] * y[ENT_10];
    r[ENT_11] = x[ENT_10] * y[ENT_01] + x[ENT_11] * y[ENT_11];
    return r;
  endfunction

  // square-and-multiply from the top exponent bit down, starting at identity
  function automatic m2p_out_t matrix_power(input m2p_in_t item);
    mat2_t    base;
    mat2_t    acc;
    m2p_out_t res;
    base[ENT_00] = item.base_00;
    base[ENT_01] = item.base_01;
    base[ENT_10] = item.base_10;
    base[ENT_11] = item.base_11;
    acc[ENT_00] = 1;
    acc[ENT_01] = 0;
    acc[ENT_10] = 0;
    acc[ENT_11] = 1;
    for (int b = EXP_WIDTH - 1; b >= 0; b--) begin
      acc = mat_product(acc, acc);
      if (item.exponent[b]) begin
        acc = mat_product(base, acc);
      end
    end
    res.power_00 = acc[ENT_00];
    res.power_01 = acc[ENT_01];
    res.power_10 = acc[ENT_10];
    res.power_11 = acc[ENT_11];
    return res;
  endfunction

  function automatic stim_row_t stim_row(input int b00, input int b01, input int b10,
                                         input int b11, input int unsigned e,
                                         input bit known, input int p00, input int p01,
                                         input int p10, input int p11);
    stim_row_t r;
    r.stim.base_00  = b00;
    r.stim.base_01  = b01;
    r.stim.base_10  = b10;
    r.stim.base_11  = b11;
    r.stim.exponent = e[EXP_WIDTH-1:0];
    r.known          = known;
    r.power.power_00 = p00;
    r.power.power_01 = p01;
    r.power.power_10 = p10;
    r.power.power_11 = p11;
    return r;
  endfunction

  // full-range words, small signed values, or corner values
  function automatic m2p_word_t pick_entry(input int kind);
    m2p_word_t w;
    case (kind)
      0: begin
        w = $urandom;
      end
      1: begin
        w = $urandom_range(0, 8) - 4;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: w = 0;
          1: w = 1;
          2: w = -1;
          3: w = WMIN;
          4: w = WMAX;
          default: w = $urandom;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic m2p_in_t random_item();
    m2p_in_t     item;
    int          kind;
    int unsigned k;
    kind = $urandom_range(0, 2);
    item.base_00 = pick_entry(kind);
    item.base_01 = pick_entry(kind);
    item.base_10 = pick_entry(kind);
    item.base_11 = pick_entry(kind);
    // exponents: any value, small, dense in set bits, or a power of two and its neighbour
    case ($urandom_range(0, 3))
      0: item.exponent = EXP_WIDTH'($urandom);
      1: item.exponent = EXP_WIDTH'($urandom_range(0, 40));
      2: item.exponent = EXP_WIDTH'($urandom | $urandom);
      default: begin
        k = $urandom_range(0, 31);
        item.exponent = EXP_WIDTH'($urandom_range(0, 1) ? (32'd1 << k)
                                                         : ((32'd1 << k) - 1));
      end
    endcase
    return item;
  endfunction

  // offer one transaction and hold it until taken, then maybe go idle
  task automatic offer(input m2p_in_t item, input bit known, input m2p_out_t fixed);
    int idle;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    power_q.push_back(known ? fixed : matrix_power(item));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      // mostly short gaps, now and then one long enough to land late in the work
      idle = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 10);
      repeat (idle) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    end
  endtask

  // sender stands back until every owed power has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (power_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic check_entry(input string name, input logic signed [DATA_WIDTH-1:0] exp_v,
                             input logic signed [DATA_WIDTH-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // receiver: check each transaction taken, then choose the next stall value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (power_q.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, expected none actual %h",
                   $time, out_data_o);
          n_errors++;
        end else begin
          want = power_q.pop_front();
          check_entry("power_00", want.power_00, out_data_o.power_00);
          check_entry("power_01", want.power_01, out_data_o.power_01);
          check_entry("power_10", want.power_10, out_data_o.power_10);
          check_entry("power_11", want.power_11, out_data_o.power_11);
        end
        n_results++;
        // long hold-off so the finished result backs up and the input stalls
        if (n_results == 30 || n_results == 1000) begin
          hold_left = 1500;
        end
      end
      if (seg_left == 0) begin
        seg_mode = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 400);
      end else begin
        seg_left--;
      end
      phase = (phase == 4) ? 0 : phase + 1;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (seg_mode)
          RX_FREE:     out_stall_i <= 1'b0;
          RX_SPARSE:   out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_stall_i <= (phase < 2);
          default:     out_stall_i <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    m2p_in_t item;

    // exponent zero gives identity whatever the base; a zero base to a power stays zero
    dir_rows.push_back(stim_row(WMAX, WMIN, WMIN, WMAX, 0, 1, 1, 0, 0, 1));
    dir_rows.push_back(stim_row(-1, -1, -1, -1, 0, 1, 1, 0, 0, 1));
    dir_rows.push_back(stim_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 1));
    dir_rows.push_back(stim_row(0, 0, 0, 0, 7, 1, 0, 0, 0, 0));
    // exponent one returns the base untouched
    dir_rows.push_back(stim_row(2, 3, 5, 7, 1, 1, 2, 3, 5, 7));
    dir_rows.push_back(stim_row(WMIN, WMAX, -1, 0, 1, 1, WMIN, WMAX, -1, 0));
    // identity at the largest exponent, sign flips, row swap
    dir_rows.push_back(stim_row(1, 0, 0, 1, EMAX, 1, 1, 0, 0, 1));
    dir_rows.push_back(stim_row(-1, 0, 0, -1, 2, 1, 1, 0, 0, 1));
    dir_rows.push_back(stim_row(-1, 0, 0, -1, 3, 1, -1, 0, 0, -1));
    dir_rows.push_back(stim_row(0, 1, 1, 0, 3, 1, 0, 1, 1, 0));
    dir_rows.push_back(stim_row(0, 1, 1, 0, 4, 1, 1, 0, 0, 1));
    // fibonacci matrix, small then wrapping
    dir_rows.push_back(stim_row(1, 1, 1, 0, 10, 1, 89, 55, 55, 34));
    dir_rows.push_back(stim_row(1, 1, 1, 0, 50, 0, 0, 0, 0, 0));
    dir_rows.push_back(stim_row(1, 1, 1, 0, EMAX, 0, 0, 0, 0, 0));
    // shear matrix carries the exponent straight into the corner
    dir_rows.push_back(stim_row(1, 1, 0, 1, 32'h4000_0000, 1, 1, 32'h4000_0000, 0, 1));
    dir_rows.push_back(stim_row(1, 1, 0, 1, EMAX, 1, 1, WMAX, 0, 1));
    // overflow wraps rather than saturating
    dir_rows.push_back(stim_row(2, 0, 0, 2, 31, 1, WMIN, 0, 0, WMIN));
    dir_rows.push_back(stim_row(2, 0, 0, 2, 32, 1, 0, 0, 0, 0));
    dir_rows.push_back(stim_row(WMAX, WMAX, WMAX, WMAX, 2, 0, 0, 0, 0, 0));
    dir_rows.push_back(stim_row(WMIN, WMIN, WMIN, WMIN, 2, 0, 0, 0, 0, 0));
    // alternating exponent bits
    dir_rows.push_back(stim_row(3, -2, 7, -5, 32'h5555_5555, 0, 0, 0, 0, 0));
    dir_rows.push_back(stim_row(-3, 2, -7, 5, 32'h2AAA_AAAA, 0, 0, 0, 0, 0));
    dir_rows.push_back(stim_row($urandom, $urandom, $urandom, $urandom, EMAX, 0,
                                0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].power);
    end
    drain();

    for (int n = 0; n < 1930; n++) begin
      item = random_item();
      offer(item, 1'b0, '0);
      if (n == 960) begin
        drain();
      end
    end
    drain();

    // let any late stray result show up
    repeat (400) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
